// File: hw/rtl/bsg_pkg.sv
// Shared types and constants for the bond segment geometry block.
// No dependencies; every other file of the block but bsg_ram imports this package.
`timescale 1ns / 1ps
package bsg_pkg;

    localparam int ATOM_SLOTS_DEFAULT = 256;
    localparam int COORD_W            = 32;
    localparam int INDEX_W            = 8;
    localparam int LEN_W              = 33;
    localparam int MAG_W              = 33;
    localparam int SQ_W               = 66;
    localparam int QUOT_W             = 31;
    localparam int ROOT_STEPS         = 33;
    localparam int QUEUE_DEPTH        = 2;
    localparam int ATOM_W             = 3 * COORD_W;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_BOND  = 1'b1;

    typedef struct packed {
        logic                      operation;
        logic [INDEX_W-1:0]        atom_index;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [INDEX_W-1:0]        first_atom;
        logic [INDEX_W-1:0]        second_atom;
    } bsg_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] mid_depth;
        logic [LEN_W-1:0]          seg_length;
        logic signed [COORD_W-1:0] unit_dx;
        logic signed [COORD_W-1:0] unit_dy;
        logic                      degenerate;
    } bsg_result_t;

    // Word handed from the front end to the back end through the queue
    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic signed [COORD_W-1:0] mid;
    } bsg_seg_t;

    localparam int SEG_W = $bits(bsg_seg_t);

    // Queue handshake between front and back
    typedef struct packed {
        logic push;
        logic pop;
    } bsg_qctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } bsg_qsts_t;

endpackage

// File: hw/rtl/bsg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bsg_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: hw/rtl/bsg_fifo.sv
// Small register queue between the front and back ends.
// Depends on bsg_pkg for the handshake structs.
`timescale 1ns / 1ps
module bsg_fifo #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bsg_pkg::bsg_qctl_t ctl,
    input  logic [WIDTH-1:0]   wdata,
    output logic [WIDTH-1:0]   rdata,
    output bsg_pkg::bsg_qsts_t sts
);
    import bsg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign sts.full  = (count_reg == CNT_W'(DEPTH));
    assign sts.empty = (count_reg == '0);
    assign do_push   = ctl.push && !sts.full;
    assign do_pop    = ctl.pop && !sts.empty;
    assign rdata     = slot_reg[rptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Hold queued words
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");
    assert property (@(posedge clk) disable iff (!rst_n)
        sts.empty |-> wptr_reg == rptr_reg)
        else $error("empty queue with pointers apart");
endmodule

// File: hw/rtl/bsg_front.sv
// Front end: accepts words, writes the atom store, reads bond endpoints.
// Depends on bsg_pkg and bsg_ram.
`timescale 1ns / 1ps
module bsg_front #(
    parameter int ATOM_SLOTS = bsg_pkg::ATOM_SLOTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  bsg_pkg::bsg_item_t item,
    input  bsg_pkg::bsg_qsts_t q_sts,
    output logic               q_push,
    output bsg_pkg::bsg_seg_t  q_word
);
    import bsg_pkg::*;

    localparam int ADDR_W = $clog2(ATOM_SLOTS);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_RD2  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t              state_reg, state_next;
    logic [INDEX_W-1:0]   second_reg;
    logic                 first_ok_reg, second_ok_reg;
    logic [ATOM_W-1:0]    first_reg, ram_rdata, second_atom_data;
    logic                 accept, we, re;
    logic [ADDR_W-1:0]    raddr;
    logic signed [COORD_W:0] zsum;

    function automatic logic in_range(input logic [INDEX_W-1:0] idx);
        in_range = ({9'b0, idx} < 17'(ATOM_SLOTS));
    endfunction

    assign full   = (state_reg != F_IDLE);
    assign accept = push && !full;
    assign we     = accept && (item.operation == OP_STORE) && in_range(item.atom_index);
    assign re     = (accept && (item.operation == OP_BOND)) || (state_reg == F_RD2);
    assign raddr  = (state_reg == F_RD2) ? ADDR_W'(second_reg) : ADDR_W'(item.first_atom);

    bsg_ram #(
        .WIDTH (ATOM_W),
        .DEPTH (ATOM_SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (ADDR_W'(item.atom_index)),
        .wdata ({item.coord_z, item.coord_y, item.coord_x}),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Slots beyond the store read as zero
    assign second_atom_data = second_ok_reg ? ram_rdata : '0;
    assign zsum = $signed({first_reg[3*COORD_W-1], first_reg[3*COORD_W-1:2*COORD_W]})
                + $signed({second_atom_data[3*COORD_W-1],
                           second_atom_data[3*COORD_W-1:2*COORD_W]});

    assign q_push      = (state_reg == F_PUSH);
    assign q_word.x1   = first_reg[COORD_W-1:0];
    assign q_word.y1   = first_reg[2*COORD_W-1:COORD_W];
    assign q_word.x2   = second_atom_data[COORD_W-1:0];
    assign q_word.y2   = second_atom_data[2*COORD_W-1:COORD_W];
    assign q_word.mid  = zsum[COORD_W:1];

    // Sequence the two endpoint reads
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept && item.operation == OP_BOND)
                begin
                    state_next = F_RD2;
                end
            end
            F_RD2:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_sts.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold bond operands
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            second_reg    <= item.second_atom;
            first_ok_reg  <= in_range(item.first_atom);
            second_ok_reg <= in_range(item.second_atom);
        end
        if (state_reg == F_RD2)
        begin
            first_reg <= first_ok_reg ? ram_rdata : '0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        q_push && q_sts.full |=> state_reg == F_PUSH)
        else $error("front left push state while queue full");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == F_RD2 |=> state_reg == F_PUSH)
        else $error("front skipped endpoint capture");
    assert property (@(posedge clk) disable iff (!rst_n)
        we |-> state_reg == F_IDLE)
        else $error("store write outside idle");
endmodule

// File: hw/rtl/bsg_back.sv
// Back end: squares, integer square root and two restoring dividers,
// then a result register. Depends on bsg_pkg.
`timescale 1ns / 1ps
module bsg_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bsg_pkg::bsg_qsts_t   q_sts,
    input  bsg_pkg::bsg_seg_t    q_word,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output bsg_pkg::bsg_result_t result
);
    import bsg_pkg::*;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_SQ   = 5'b00010,
        B_ROOT = 5'b00100,
        B_DIV  = 5'b01000,
        B_DONE = 5'b10000
    } bstate_t;

    bstate_t            state_reg, state_next;
    bsg_seg_t           seg_reg;
    logic [5:0]         cnt_reg;
    logic [MAG_W-1:0]   ax_reg, ay_reg;
    logic               sx_reg, sy_reg;
    logic [49:0]        prod_reg;
    logic               prod_hi_reg;
    logic [SQ_W-1:0]    acc_reg;
    logic [35:0]        rem_reg;
    logic [LEN_W-1:0]   root_reg;
    logic [33:0]        remx_reg, remy_reg;
    logic [QUOT_W-1:0]  lowx_reg, lowy_reg, qx_reg, qy_reg;
    logic               deg_reg;
    bsg_result_t        out_reg;
    logic               out_valid_reg;

    logic signed [COORD_W:0] dx, dy;
    logic [MAG_W-1:0]   mul_a;
    logic [16:0]        mul_b;
    logic [SQ_W-1:0]    prod_ext;
    logic [35:0]        rem_sh, trial;
    logic [33:0]        rx_sh, ry_sh;
    logic               take_out;

    assign dx = $signed({q_word.x2[COORD_W-1], q_word.x2})
              - $signed({q_word.x1[COORD_W-1], q_word.x1});
    assign dy = $signed({q_word.y2[COORD_W-1], q_word.y2})
              - $signed({q_word.y1[COORD_W-1], q_word.y1});

    assign q_pop    = (state_reg == B_IDLE) && !q_sts.empty;
    assign take_out = (state_reg == B_DONE) && (!out_valid_reg || pop);
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    // Square operands: low 17 bits then high 16 bits of each magnitude
    assign mul_a    = cnt_reg[1] ? ay_reg : ax_reg;
    assign mul_b    = cnt_reg[0] ? {1'b0, mul_a[32:17]} : mul_a[16:0];
    assign prod_ext = prod_hi_reg ? {prod_reg[48:0], 17'b0} : {16'b0, prod_reg};

    // Root step: bring down two bits, try subtracting 4*root+1
    assign rem_sh = {rem_reg[33:0], acc_reg[SQ_W-1:SQ_W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    // Divider step: bring down one numerator bit
    assign rx_sh = {remx_reg[32:0], lowx_reg[QUOT_W-1]};
    assign ry_sh = {remy_reg[32:0], lowy_reg[QUOT_W-1]};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_sts.empty)
                begin
                    state_next = B_SQ;
                end
            end
            B_SQ:
            begin
                if (cnt_reg == 6'd4)
                begin
                    state_next = B_ROOT;
                end
            end
            B_ROOT:
            begin
                if (cnt_reg == 6'(ROOT_STEPS - 1))
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (root_reg == '0 || cnt_reg == 6'(QUOT_W))
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (take_out)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                seg_reg     <= q_word;
                sx_reg      <= dx[COORD_W];
                sy_reg      <= dy[COORD_W];
                ax_reg      <= dx[COORD_W] ? MAG_W'(-dx) : MAG_W'(dx);
                ay_reg      <= dy[COORD_W] ? MAG_W'(-dy) : MAG_W'(dy);
                acc_reg     <= '0;
                cnt_reg     <= '0;
                prod_hi_reg <= 1'b0;
                prod_reg    <= '0;
            end
            B_SQ:
            begin
                prod_reg    <= mul_a * mul_b;
                prod_hi_reg <= cnt_reg[0];
                acc_reg     <= acc_reg + prod_ext;
                if (cnt_reg == 6'd4)
                begin
                    cnt_reg  <= '0;
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            B_ROOT:
            begin
                acc_reg <= {acc_reg[SQ_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[LEN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[LEN_W-2:0], 1'b0};
                end
                if (cnt_reg == 6'(ROOT_STEPS - 1))
                begin
                    cnt_reg  <= '0;
                    remx_reg <= {2'b0, ax_reg[32:1]};
                    remy_reg <= {2'b0, ay_reg[32:1]};
                    lowx_reg <= {ax_reg[0], 30'b0};
                    lowy_reg <= {ay_reg[0], 30'b0};
                    qx_reg   <= '0;
                    qy_reg   <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            B_DIV:
            begin
                deg_reg  <= (root_reg == '0);
                cnt_reg  <= cnt_reg + 1'b1;
                lowx_reg <= {lowx_reg[QUOT_W-2:0], 1'b0};
                lowy_reg <= {lowy_reg[QUOT_W-2:0], 1'b0};
                if (cnt_reg != 6'(QUOT_W))
                begin
                    if (rx_sh >= {1'b0, root_reg})
                    begin
                        remx_reg <= rx_sh - {1'b0, root_reg};
                        qx_reg   <= {qx_reg[QUOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        remx_reg <= rx_sh;
                        qx_reg   <= {qx_reg[QUOT_W-2:0], 1'b0};
                    end
                    if (ry_sh >= {1'b0, root_reg})
                    begin
                        remy_reg <= ry_sh - {1'b0, root_reg};
                        qy_reg   <= {qy_reg[QUOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        remy_reg <= ry_sh;
                        qy_reg   <= {qy_reg[QUOT_W-2:0], 1'b0};
                    end
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (take_out)
        begin
            out_reg.start_x    <= seg_reg.x1;
            out_reg.start_y    <= seg_reg.y1;
            out_reg.end_x      <= seg_reg.x2;
            out_reg.end_y      <= seg_reg.y2;
            out_reg.mid_depth  <= seg_reg.mid;
            out_reg.seg_length <= root_reg;
            out_reg.degenerate <= deg_reg;
            if (deg_reg)
            begin
                out_reg.unit_dx <= '0;
                out_reg.unit_dy <= '0;
            end
            else
            begin
                out_reg.unit_dx <= sx_reg ? -{1'b0, qx_reg} : {1'b0, qx_reg};
                out_reg.unit_dy <= sy_reg ? -{1'b0, qy_reg} : {1'b0, qy_reg};
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.degenerate |->
            result.unit_dx == '0 && result.unit_dy == '0 && result.seg_length == '0)
        else $error("degenerate result with nonzero fields");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == B_SQ)
        else $error("back end took a word without starting");
endmodule

// File: hw/rtl/bond_segment_geometry.sv
// Top level of the bond segment geometry block.
// Depends on bsg_pkg, bsg_front, bsg_fifo and bsg_back.
//
// Usage: words enter on push/full carrying an operation code. A store word
// writes the x, y, z coordinates of one atom into the atom store and yields
// no result. A bond word reads two stored atoms and yields one result word
// on empty/pop: both endpoints' x and y, the mid depth, the floor planar
// length and the Q2.30 unit direction, with degenerate set for zero length.
// Store words are taken one per cycle while the front end is idle. The front
// end takes a bond word, then is busy through two store reads on the single
// read port and until it hands the endpoints to a 2-word queue. For each
// bond the back end takes the word, forms the squares on one 33x17
// multiplier, runs the bit-pair square root, then the two restoring
// dividers side by side, and loads the result register.
// The front end can take the next bond word while the back end still works
// on an earlier one; sustained throughput is set by the back end's root and
// divide loops.
// Reset empties the queue and the result register; the atom store keeps no
// reset value and a slot must be written before a bond reads it. When the
// receiver does not pop, the result waits while the back end finishes the
// next bond, and the queue then fills and full rises.
`timescale 1ns / 1ps
module bond_segment_geometry #(
    parameter int ATOM_SLOTS = bsg_pkg::ATOM_SLOTS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  bsg_pkg::bsg_item_t   item,
    output logic                 empty,
    input  logic                 pop,
    output bsg_pkg::bsg_result_t result
);
    import bsg_pkg::*;

    bsg_qctl_t q_ctl;
    bsg_qsts_t q_sts;
    bsg_seg_t  q_in, q_out;
    logic [SEG_W-1:0] q_rdata;
    logic      q_push, q_pop;

    // Gather the queue handshake from both ends
    assign q_ctl = '{push: q_push, pop: q_pop};

    bsg_front #(
        .ATOM_SLOTS (ATOM_SLOTS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_sts  (q_sts),
        .q_push (q_push),
        .q_word (q_in)
    );

    bsg_fifo #(
        .WIDTH (SEG_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (q_ctl),
        .wdata (q_in),
        .rdata (q_rdata),
        .sts   (q_sts)
    );

    assign q_out = q_rdata;

    bsg_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_sts  (q_sts),
        .q_word (q_out),
        .q_pop  (q_pop),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );
endmodule

// File: bench/bond_segment_geometry_tb.sv
// Testbench for the bond segment geometry block: directed and random store and bond words.
// Depends on bsg_pkg and bond_segment_geometry; predicts each bond result in place.
`timescale 1ns / 1ps
module bond_segment_geometry_tb;
    import bsg_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    bsg_item_t   item;
    logic        empty;
    logic        pop;
    bsg_result_t result;

    bond_segment_geometry dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // Shadow copy of the atom store and the slots written so far
    logic signed [COORD_W-1:0] atom_x [256];
    logic signed [COORD_W-1:0] atom_y [256];
    logic signed [COORD_W-1:0] atom_z [256];
    bit                        atom_written [256];

    bsg_result_t pending_bonds [$];
    int          error_count;
    int          send_idle_pct;
    int          take_idle_pct;

    // Free-running clock, 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hold the run to a fixed ceiling
    initial
    begin
        #40ms;
        $display("bond_segment_geometry_tb: errors");
        $finish;
    end

    // Truncated Q2.30 quotient of a signed difference by the length
    function automatic logic signed [31:0] unit_component(longint diff, longint unsigned len);
        longint unsigned mag;
        longint unsigned quot;
        mag  = diff < 0 ? -diff : diff;
        quot = (mag << 30) / len;
        return 32'(diff < 0 ? -quot : quot);
    endfunction

    function automatic bsg_result_t bond_geometry(logic [7:0] a, logic [7:0] b);
        bsg_result_t          r;
        longint               dx;
        longint               dy;
        longint unsigned      adx;
        longint unsigned      ady;
        logic [65:0]          sq_sum;
        logic [65:0]          cand_sq;
        logic [32:0]          root;
        logic [32:0]          cand;
        logic signed [33:0]   zsum;
        r.start_x   = atom_x[a];
        r.start_y   = atom_y[a];
        r.end_x     = atom_x[b];
        r.end_y     = atom_y[b];
        zsum        = 34'(atom_z[a]) + 34'(atom_z[b]);
        r.mid_depth = 32'(zsum >>> 1);
        dx = longint'(atom_x[b]) - longint'(atom_x[a]);
        dy = longint'(atom_y[b]) - longint'(atom_y[a]);
        // Square the magnitudes so the 64-bit products stay unsigned
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        sq_sum = 66'(adx * adx) + 66'(ady * ady);
        root = '0;
        // Build the floor square root one bit at a time
        for (int bitpos = 32; bitpos >= 0; bitpos--)
        begin
            cand    = root | (33'd1 << bitpos);
            cand_sq = 66'(cand) * 66'(cand);
            if (cand_sq <= sq_sum)
                root = cand;
        end
        r.seg_length = root;
        if (root == 0)
        begin
            r.unit_dx    = '0;
            r.unit_dy    = '0;
            r.degenerate = 1'b1;
        end
        else
        begin
            r.unit_dx    = unit_component(dx, root);
            r.unit_dy    = unit_component(dy, root);
            r.degenerate = 1'b0;
        end
        return r;
    endfunction

    // Drive one word and wait for it to be taken; push stays high afterwards
    task automatic send_word(bsg_item_t w);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            push <= 1'b0;
            item <= bsg_item_t'($urandom());
            @(negedge clk);
        end
        item <= w;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (w.operation == OP_STORE)
        begin
            atom_x[w.atom_index]       = w.coord_x;
            atom_y[w.atom_index]       = w.coord_y;
            atom_z[w.atom_index]       = w.coord_z;
            atom_written[w.atom_index] = 1'b1;
        end
        else
            pending_bonds.push_back(bond_geometry(w.first_atom, w.second_atom));
        @(negedge clk);
    endtask

    task automatic store_atom(logic [7:0] slot, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        bsg_item_t w;
        w             = '0;
        w.operation   = OP_STORE;
        w.atom_index  = slot;
        w.coord_x     = x;
        w.coord_y     = y;
        w.coord_z     = z;
        w.first_atom  = $urandom();
        w.second_atom = $urandom();
        send_word(w);
    endtask

    task automatic bond_atoms(logic [7:0] a, logic [7:0] b);
        bsg_item_t w;
        w             = bsg_item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
        w.operation   = OP_BOND;
        w.first_atom  = a;
        w.second_atom = b;
        send_word(w);
    endtask

    function automatic logic [7:0] written_slot();
        logic [7:0] s;
        do
            s = $urandom_range(255, 0);
        while (!atom_written[s]);
        return s;
    endfunction

    function automatic logic [31:0] random_coord();
        case ($urandom_range(5, 0))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(32'h0003_0000, 0) - 32'h0001_8000;
            default: return $urandom();
        endcase
    endfunction

    // Compare each taken result with the oldest expected one
    always @(posedge clk)
    begin
        bsg_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_bonds.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                error_count++;
            end
            else
            begin
                want = pending_bonds.pop_front();
                if (result !== want)
                begin
                    $display("%0t: expected %h actual %h", $time, want, result);
                    error_count++;
                end
            end
        end
    end

    // Receiver stalls at random
    always @(negedge clk)
        pop <= ($urandom_range(99, 0) >= take_idle_pct);

    task automatic test_extremes();
        store_atom(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        store_atom(255, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        store_atom(1, 32'h0, 32'h0, 32'hffff_ffff);
        store_atom(2, 32'h0001_0000, 32'h0, 32'hffff_ffff);
        store_atom(3, 32'h0, 32'hffff_0000, 32'h1);
        bond_atoms(0, 255);
        bond_atoms(255, 0);
        bond_atoms(1, 2);
        bond_atoms(2, 1);
        bond_atoms(1, 3);
        bond_atoms(0, 1);
        bond_atoms(255, 1);
    endtask

    // Zero length: same slot, or two slots at one place
    task automatic test_degenerate();
        store_atom(4, 32'h1234_5678, 32'h8765_4321, 32'h8000_0001);
        store_atom(5, 32'h1234_5678, 32'h8765_4321, 32'h7fff_ffff);
        bond_atoms(4, 4);
        bond_atoms(4, 5);
        bond_atoms(255, 255);
        store_atom(6, 32'h0, 32'h0, 32'h0);
        bond_atoms(6, 1);
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(2, 0) == 0)
                store_atom($urandom_range(255, 0), random_coord(), random_coord(), random_coord());
            else
                bond_atoms(written_slot(), written_slot());
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        item          = '0;
        error_count   = 0;
        send_idle_pct = 8;
        take_idle_pct = 51;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        test_extremes();
        test_degenerate();
        test_random(510);
        send_idle_pct = 51;
        take_idle_pct = 8;
        test_random(510);
        send_idle_pct = 0;
        take_idle_pct = 0;
        test_random(510);
        push <= 1'b0;
        while (pending_bonds.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (error_count == 0)
            $display("bond_segment_geometry_tb: clean");
        else
            $display("bond_segment_geometry_tb: errors");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/bsg_pkg.sv
hw/rtl/bsg_ram.sv
hw/rtl/bsg_fifo.sv
hw/rtl/bsg_front.sv
hw/rtl/bsg_back.sv
hw/rtl/bond_segment_geometry.sv
bench/bond_segment_geometry_tb.sv
